// ----- hw/rtl/ax25fa_pkg.sv -----
// shared types, constants and functions of the ax25 ui frame assembler
// no dependencies; imported by every module of the block

package ax25fa_pkg;

   localparam int MAX_FRAME_BYTES = 512;
   localparam int FRAME_BYTES_W = 10;
   localparam logic [FRAME_BYTES_W-1:0] BODY_LIMIT = FRAME_BYTES_W'(MAX_FRAME_BYTES - 2);

   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_PTR_W = 2;
   localparam int CMDQ_CNT_W = 3;

   localparam logic [7:0]  SPACE_SHIFTED = 8'h40;
   localparam logic [7:0]  CHAR_HYPHEN = 8'h2d;
   localparam logic [7:0]  CHAR_ZERO = 8'h30;
   localparam logic [7:0]  CHAR_NINE = 8'h39;
   localparam logic [7:0]  CRRL_FIRST = 8'he0;
   localparam logic [7:0]  CRRL_SECOND = 8'h60;
   localparam logic [7:0]  CRRL_THIRD = 8'h61;
   localparam logic [7:0]  SSID_LIMIT = 8'd16;
   localparam logic [7:0]  SSID_MASK = 8'h0f;
   localparam logic [15:0] CRC_INIT = 16'hffff;
   localparam logic [15:0] CRC_XOROUT = 16'hffff;
   localparam logic [15:0] CRC_POLY = 16'h8408;
   localparam logic [7:0]  CONTROL_RESET = 8'h03;
   localparam logic [7:0]  PROTOCOL_RESET = 8'hf0;

   typedef enum logic [1:0] {
      KIND_ADDR_CHAR = 2'd0,
      KIND_ADDR_END  = 2'd1,
      KIND_DATA      = 2'd2,
      KIND_FRAME_END = 2'd3
   } kind_type;

   typedef enum logic {
      CSR_CONTROL  = 1'b0,
      CSR_PROTOCOL = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      SSID_NONE   = 2'd0,
      SSID_FIRST  = 2'd1,
      SSID_SECOND = 2'd2,
      SSID_DONE   = 2'd3
   } ssid_phase_type;

   typedef enum logic [1:0] {
      CMD_BYTE      = 2'd0,
      CMD_ADDR_END  = 2'd1,
      CMD_FRAME_END = 2'd2
   } cmd_op_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] char_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       overflow;
   } rsp_type;

   typedef struct packed {
      cmd_op_type op;
      logic [7:0] data;
      logic [2:0] pad;
      logic       with_ctl;
   } cmd_type;

   function automatic logic [15:0] crc16_x25_byte(input logic [15:0] crc,
                                                  input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- hw/rtl/ax25fa_front.sv -----
// front end: parses address characters and item kinds into commands
// depends on ax25fa_pkg

module ax25fa_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  ax25fa_pkg::req_type req_data,
   output logic                cmd_push,
   output ax25fa_pkg::cmd_type cmd_data
);
   import ax25fa_pkg::*;

   logic [1:0]     addr_count_ff, addr_count_in;
   logic [2:0]     char_pos_ff, char_pos_in;
   ssid_phase_type ssid_phase_ff, ssid_phase_in;
   logic [7:0]     ssid_value_ff, ssid_value_in;

   logic [7:0] c;
   logic [7:0] digit;
   logic [7:0] times10;
   logic [7:0] ssid_masked;
   logic [7:0] crrl;
   logic       is_digit;

   assign c = req_data.char_byte;
   assign digit = c - CHAR_ZERO;
   assign times10 = {ssid_value_ff[4:0], 3'b000} + {ssid_value_ff[6:0], 1'b0};
   assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign ssid_masked = (ssid_value_ff >= SSID_LIMIT) ? (ssid_value_ff & SSID_MASK)
                                                      : ssid_value_ff;

   always_comb begin
      unique case (addr_count_ff)
         2'd0:    crrl = CRRL_FIRST;
         2'd1:    crrl = CRRL_SECOND;
         default: crrl = CRRL_THIRD;
      endcase
   end

   always_comb begin
      addr_count_in = addr_count_ff;
      char_pos_in = char_pos_ff;
      ssid_phase_in = ssid_phase_ff;
      ssid_value_in = ssid_value_ff;
      cmd_push = 1'b0;
      cmd_data.op = CMD_BYTE;
      cmd_data.data = c;
      cmd_data.pad = 3'd0;
      cmd_data.with_ctl = 1'b0;
      if (accept) begin
         unique case (req_data.kind)
            KIND_ADDR_CHAR: begin
               if (addr_count_ff != 2'd3) begin
                  unique case (ssid_phase_ff)
                     SSID_FIRST: begin
                        ssid_value_in = digit;
                        ssid_phase_in = SSID_SECOND;
                     end
                     SSID_SECOND: begin
                        if (is_digit) begin
                           ssid_value_in = times10 + digit;
                        end
                        ssid_phase_in = SSID_DONE;
                     end
                     SSID_DONE: begin
                     end
                     default: begin
                        if (char_pos_ff < 3'd6) begin
                           cmd_push = 1'b1;
                           if (c == CHAR_HYPHEN) begin
                              ssid_phase_in = SSID_FIRST;
                              cmd_data.data = SPACE_SHIFTED;
                           end else begin
                              cmd_data.data = {c[6:0], 1'b0};
                           end
                           char_pos_in = char_pos_ff + 3'd1;
                        end else if (char_pos_ff == 3'd6) begin
                           if (c == CHAR_HYPHEN) begin
                              ssid_phase_in = SSID_FIRST;
                           end
                           char_pos_in = 3'd7;
                        end
                     end
                  endcase
               end
            end
            KIND_ADDR_END: begin
               if (addr_count_ff != 2'd3) begin
                  cmd_push = 1'b1;
                  cmd_data.op = CMD_ADDR_END;
                  cmd_data.data = crrl | {ssid_masked[6:0], 1'b0};
                  cmd_data.pad = (char_pos_ff > 3'd6) ? 3'd0 : 3'd6 - char_pos_ff;
                  cmd_data.with_ctl = (addr_count_ff == 2'd2);
                  addr_count_in = addr_count_ff + 2'd1;
                  char_pos_in = 3'd0;
                  ssid_phase_in = SSID_NONE;
                  ssid_value_in = 8'd0;
               end
            end
            KIND_DATA: begin
               cmd_push = (addr_count_ff == 2'd3);
            end
            KIND_FRAME_END: begin
               cmd_push = 1'b1;
               cmd_data.op = CMD_FRAME_END;
               addr_count_in = 2'd0;
               char_pos_in = 3'd0;
               ssid_phase_in = SSID_NONE;
               ssid_value_in = 8'd0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_count_ff <= 2'd0;
         char_pos_ff <= 3'd0;
         ssid_phase_ff <= SSID_NONE;
         ssid_value_ff <= 8'd0;
      end else begin
         addr_count_ff <= addr_count_in;
         char_pos_ff <= char_pos_in;
         ssid_phase_ff <= ssid_phase_in;
         ssid_value_ff <= ssid_value_in;
      end
   end

endmodule

// ----- hw/rtl/ax25fa_cmdq.sv -----
// short command queue between the front and back ends
// depends on ax25fa_pkg

module ax25fa_cmdq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  ax25fa_pkg::cmd_type                 push_data,
   input  logic                                pop,
   output logic                                valid,
   output ax25fa_pkg::cmd_type                 head,
   output logic                                full,
   output logic [ax25fa_pkg::CMDQ_CNT_W-1:0]   count
);
   import ax25fa_pkg::*;

   cmd_type                 slots_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]   count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign full = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign valid = (count_ff != '0);
   assign head = slots_ff[rd_ptr_ff];
   assign count = count_ff;
   assign do_push = push && !full;
   assign do_pop = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/ax25fa_back.sv -----
// back end: expands commands into frame bytes, keeps crc and frame limit
// depends on ax25fa_pkg; holds the control and pid registers

module ax25fa_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  ax25fa_pkg::csr_index_type csr_index,
   input  logic [7:0]                csr_wdata,
   input  logic                      cmd_valid,
   input  ax25fa_pkg::cmd_type       cmd_head,
   output logic                      cmd_pop,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output ax25fa_pkg::rsp_type       rsp_data
);
   import ax25fa_pkg::*;

   logic [7:0]               control_ff;
   logic [7:0]               protocol_ff;
   logic [3:0]               step_ff, step_in;
   logic [15:0]              crc_ff, crc_in;
   logic [FRAME_BYTES_W-1:0] frame_bytes_ff, frame_bytes_in;
   logic                     dropped_ff, dropped_in;
   logic                     out_valid_ff, out_valid_in;
   rsp_type                  out_data_ff;

   logic       advance;
   logic       last_step;
   logic [3:0] addr_last;
   logic [3:0] sub;
   logic [7:0] body_byte;
   logic       fits;
   logic       emit;
   rsp_type    emit_data;
   logic [15:0] crc_out;

   assign advance = cmd_valid && (!out_valid_ff || rsp_pop);
   assign addr_last = {1'b0, cmd_head.pad} + (cmd_head.with_ctl ? 4'd2 : 4'd0);
   assign sub = step_ff - {1'b0, cmd_head.pad};
   assign fits = (frame_bytes_ff < BODY_LIMIT);
   assign crc_out = crc_ff ^ CRC_XOROUT;

   always_comb begin
      unique case (cmd_head.op)
         CMD_ADDR_END:  last_step = (step_ff == addr_last);
         CMD_FRAME_END: last_step = (step_ff == 4'd1);
         default:       last_step = 1'b1;
      endcase
   end

   always_comb begin
      body_byte = cmd_head.data;
      if (cmd_head.op == CMD_ADDR_END) begin
         if (step_ff < {1'b0, cmd_head.pad}) begin
            body_byte = SPACE_SHIFTED;
         end else begin
            case (sub)
               4'd0:    body_byte = cmd_head.data;
               4'd1:    body_byte = control_ff;
               default: body_byte = protocol_ff;
            endcase
         end
      end
   end

   always_comb begin
      step_in = step_ff;
      crc_in = crc_ff;
      frame_bytes_in = frame_bytes_ff;
      dropped_in = dropped_ff;
      cmd_pop = 1'b0;
      emit = 1'b0;
      emit_data.out_byte = body_byte;
      emit_data.last = 1'b0;
      emit_data.overflow = dropped_ff;
      if (advance) begin
         cmd_pop = last_step;
         step_in = last_step ? 4'd0 : step_ff + 4'd1;
         if (cmd_head.op == CMD_FRAME_END) begin
            emit = 1'b1;
            if (step_ff == 4'd0) begin
               emit_data.out_byte = crc_out[7:0];
            end else begin
               emit_data.out_byte = crc_out[15:8];
               emit_data.last = 1'b1;
               crc_in = CRC_INIT;
               frame_bytes_in = '0;
               dropped_in = 1'b0;
            end
         end else if (fits) begin
            emit = 1'b1;
            crc_in = crc16_x25_byte(crc_ff, body_byte);
            frame_bytes_in = frame_bytes_ff + 1'b1;
         end else begin
            dropped_in = 1'b1;
         end
      end
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff <= CONTROL_RESET;
         protocol_ff <= PROTOCOL_RESET;
         step_ff <= 4'd0;
         crc_ff <= CRC_INIT;
         frame_bytes_ff <= '0;
         dropped_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_CONTROL:  control_ff <= csr_wdata;
               CSR_PROTOCOL: protocol_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         step_ff <= step_in;
         crc_ff <= crc_in;
         frame_bytes_ff <= frame_bytes_in;
         dropped_ff <= dropped_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_data_ff <= emit_data;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data = out_data_ff;

endmodule

// ----- hw/rtl/ax25_ui_frame_assembler.sv -----
// ax25 ui frame assembler (no flags) with crc-16/x.25 trailer
// accepted items pass through the command queue; each rsp byte comes from a register
// throughput: one item per cycle unless full; the back end emits one byte per cycle
// if rsp drains; during an address end (up to 9 bytes) a 4-entry queue takes input
// reset: synchronous, clears all parser and crc state, control 0x03, pid 0xf0
// depends on ax25fa_pkg, ax25fa_front, ax25fa_cmdq, ax25fa_back

module ax25_ui_frame_assembler (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  ax25fa_pkg::req_type       req_data,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output ax25fa_pkg::rsp_type       rsp_data,
   input  logic                      csr_write,
   input  ax25fa_pkg::csr_index_type csr_index,
   input  logic [7:0]                csr_wdata
);
   import ax25fa_pkg::*;

   logic                  accept;
   logic                  cmd_push;
   cmd_type               cmd_in;
   logic                  cmd_pop;
   logic                  cmd_valid;
   cmd_type               cmd_head;
   logic [CMDQ_CNT_W-1:0] cmd_count;

   assign accept = req_push && !req_full;

   ax25fa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd_data (cmd_in)
   );

   ax25fa_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (cmd_pop),
      .valid     (cmd_valid),
      .head      (cmd_head),
      .full      (req_full),
      .count     (cmd_count)
   );

   ax25fa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_cmdq_bound: assert property (@(posedge clock) disable iff (reset)
      cmd_count <= CMDQ_CNT_W'(CMDQ_DEPTH))
      else $error("command queue count out of range");

   a_pop_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("back end popped an empty command queue");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd_push && !req_full && !cmd_pop) |=> cmd_count == $past(cmd_count) + 1'b1)
      else $error("command queue lost a transfer");

   a_idle_no_output: assert property (@(posedge clock) disable iff (reset)
      (rsp_empty && !cmd_valid) |=> rsp_empty)
      else $error("result appeared without a command");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// self-checking testbench for ax25_ui_frame_assembler: predicts every frame byte, crc trailer
// and overflow flag from the accepted requests and checks each popped response against it
// depends on ax25fa_pkg and the assembler rtl

module testbench;
   import ax25fa_pkg::*;

   localparam int HALF_PERIOD = 4;
   localparam int RESET_CYCLES = 2;
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_ITEMS = 400;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int CYCLE_LIMIT = 1_000_000;

   class ui_frame_checker;
      rsp_type        expected_bytes[$];
      logic [7:0]     control_value;
      logic [7:0]     pid_value;
      logic [15:0]    crc;
      logic [1:0]     addr_count;
      logic [2:0]     char_pos;
      logic           hyphen;
      ssid_phase_type phase;
      logic [7:0]     ssid;
      logic [9:0]     body_count;
      logic           dropped;
      int             failures;

      function new();
         control_value = CONTROL_RESET;
         pid_value = PROTOCOL_RESET;
         failures = 0;
         clear_frame();
      endfunction

      function void clear_address();
         char_pos = 3'd0;
         hyphen = 1'b0;
         phase = SSID_NONE;
         ssid = 8'd0;
      endfunction

      function void clear_frame();
         crc = CRC_INIT;
         addr_count = 2'd0;
         body_count = '0;
         dropped = 1'b0;
         clear_address();
      endfunction

      function void write_register(csr_index_type index, logic [7:0] value);
         if (index == CSR_CONTROL)
            control_value = value;
         else
            pid_value = value;
      endfunction

      function void queue_byte(logic [7:0] b, logic last);
         rsp_type r;
         r.out_byte = b;
         r.last = last;
         r.overflow = dropped;
         expected_bytes.push_back(r);
      endfunction

      function void body_byte(logic [7:0] b);
         if (body_count < BODY_LIMIT) begin
            crc = crc ^ {8'h00, b};
            for (int k = 0; k < 8; k++)
               crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            body_count++;
            queue_byte(b, 1'b0);
         end else begin
            dropped = 1'b1;
         end
      endfunction

      function void address_char(logic [7:0] c);
         if (phase == SSID_FIRST) begin
            ssid = c - CHAR_ZERO;
            phase = SSID_SECOND;
         end else if (phase == SSID_SECOND) begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
               ssid = ssid * 8'd10 + (c - CHAR_ZERO);
            phase = SSID_DONE;
         end else if (phase != SSID_DONE && !hyphen) begin
            if (char_pos < 3'd6) begin
               if (c == CHAR_HYPHEN) begin
                  hyphen = 1'b1;
                  phase = SSID_FIRST;
                  body_byte(SPACE_SHIFTED);
               end else begin
                  body_byte({c[6:0], 1'b0});
               end
               char_pos++;
            end else if (char_pos == 3'd6) begin
               if (c == CHAR_HYPHEN) begin
                  hyphen = 1'b1;
                  phase = SSID_FIRST;
               end
               char_pos = 3'd7;
            end
         end
      endfunction

      function void address_end();
         logic [7:0] id;
         logic [7:0] crrl;
         logic [2:0] pos;
         id = ssid;
         pos = (char_pos > 3'd6) ? 3'd6 : char_pos;
         while (pos < 3'd6) begin
            body_byte(SPACE_SHIFTED);
            pos++;
         end
         if (id >= SSID_LIMIT)
            id = id & SSID_MASK;
         crrl = (addr_count == 2'd0) ? CRRL_FIRST : (addr_count == 2'd1) ? CRRL_SECOND : CRRL_THIRD;
         body_byte(crrl | {id[6:0], 1'b0});
         if (addr_count == 2'd2) begin
            body_byte(control_value);
            body_byte(pid_value);
         end
         addr_count++;
         clear_address();
      endfunction

      function void predict_item(req_type item);
         logic [15:0] sum;
         case (item.kind)
            KIND_ADDR_CHAR: if (addr_count < 2'd3) address_char(item.char_byte);
            KIND_ADDR_END: if (addr_count < 2'd3) address_end();
            KIND_DATA: if (addr_count == 2'd3) body_byte(item.char_byte);
            default: begin
               sum = crc ^ CRC_XOROUT;
               queue_byte(sum[7:0], 1'b0);
               queue_byte(sum[15:8], 1'b1);
               clear_frame();
            end
         endcase
      endfunction

      function void report(string msg);
         failures++;
         if (failures <= 10)
            $display("%s", msg);
      endfunction

      function void check_byte(rsp_type got);
         rsp_type want;
         if (expected_bytes.size() == 0) begin
            report($sformatf("unexpected byte %h last %b overflow %b",
                             got.out_byte, got.last, got.overflow));
         end else begin
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte || got.last !== want.last ||
                got.overflow !== want.overflow)
               report($sformatf("mismatch: byte %h last %b overflow %b, expected %h %b %b",
                                got.out_byte, got.last, got.overflow,
                                want.out_byte, want.last, want.overflow));
         end
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_push = 1'b0;
   logic          req_full;
   req_type       req_data = '0;
   logic          rsp_empty;
   logic          rsp_pop = 1'b0;
   rsp_type       rsp_data;
   logic          csr_write = 1'b0;
   csr_index_type csr_index = CSR_CONTROL;
   logic [7:0]    csr_wdata = 8'h00;

   ui_frame_checker frames = new();
   int  item_count = 0;
   int  cycle_count = 0;
   bit  send_calm = 1'b0;
   bit  hold_request = 1'b0;
   int  hold_cycles = 0;

   ax25_ui_frame_assembler dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_push && !req_full)
         frames.predict_item(req_data);
      if (!reset && rsp_pop && !rsp_empty)
         frames.check_byte(rsp_data);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // result side: random stalls, calm stretches and one long hold-off on request
   initial begin
      int  wait_cycles;
      int  count;
      bit  calm;
      count = 0;
      calm = 1'b0;
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_pop <= 1'b0;
            for (int k = 0; k < hold_cycles; k++)
               @(posedge clock);
            hold_request = 1'b0;
         end
         if (count % 32 == 0)
            calm = ($urandom_range(0, 3) == 0);
         count++;
         wait_cycles = calm ? 0 : ($urandom_range(0, 1) ? $urandom_range(0, 19) : 0);
         if (wait_cycles > 0) begin
            rsp_pop <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   task automatic send_item(kind_type kind, logic [7:0] b);
      int gap;
      gap = send_calm ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= '{kind: kind, char_byte: b};
      req_push <= 1'b1;
      item_count++;
      do @(posedge clock); while (req_full);
   endtask

   task automatic send_address(string s);
      for (int i = 0; i < s.len(); i++)
         send_item(KIND_ADDR_CHAR, s[i]);
      send_item(KIND_ADDR_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_random_address();
      int len;
      int ssid_len;
      int pick;
      len = $urandom_range(0, 8);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 9);
         send_item(KIND_ADDR_CHAR, (pick == 0) ? 8'($urandom_range(0, 255)) :
                                   (pick < 3) ? CHAR_ZERO + 8'($urandom_range(0, 9)) :
                                   8'h41 + 8'($urandom_range(0, 25)));
      end
      if ($urandom_range(0, 2) != 0) begin
         send_item(KIND_ADDR_CHAR, CHAR_HYPHEN);
         ssid_len = $urandom_range(0, 3);
         for (int i = 0; i < ssid_len; i++) begin
            pick = $urandom_range(0, 9);
            send_item(KIND_ADDR_CHAR, (pick == 0) ? CHAR_HYPHEN :
                                      (pick == 1) ? 8'($urandom_range(0, 255)) :
                                      CHAR_ZERO + 8'($urandom_range(0, 9)));
         end
      end
      send_item(KIND_ADDR_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_random_frame();
      int shape;
      int addr_total;
      int data_total;
      shape = $urandom_range(0, 11);
      send_calm = ($urandom_range(0, 3) == 0);
      if (shape == 0) begin
         repeat ($urandom_range(1, 8))
            send_item(kind_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
         if (shape == 1)
            repeat ($urandom_range(1, 3)) send_item(KIND_DATA, 8'($urandom_range(0, 255)));
         addr_total = (shape == 2) ? $urandom_range(0, 2) : (shape == 3) ? 4 : 3;
         repeat (addr_total) send_random_address();
         data_total = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
         if (addr_total >= 3)
            repeat (data_total) send_item(KIND_DATA, 8'($urandom_range(0, 255)));
      end
      send_item(KIND_FRAME_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic wait_for_idle();
      req_push <= 1'b0;
      do @(posedge clock); while (frames.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_registers(logic [7:0] control_value, logic [7:0] pid_value);
      csr_write <= 1'b1;
      csr_index <= CSR_CONTROL;
      csr_wdata <= control_value;
      frames.write_register(CSR_CONTROL, control_value);
      @(posedge clock);
      csr_index <= CSR_PROTOCOL;
      csr_wdata <= pid_value;
      frames.write_register(CSR_PROTOCOL, pid_value);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      int target;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed frames on reset register values
      send_item(KIND_DATA, 8'hff);
      send_item(KIND_ADDR_CHAR, 8'hff);
      send_address("-999");
      send_item(KIND_ADDR_CHAR, 8'h00);
      send_address("");
      send_address("ABCDEF-");
      send_item(KIND_DATA, 8'h00);
      send_item(KIND_DATA, 8'hff);
      send_address("Z");
      send_item(KIND_FRAME_END, 8'h00);
      send_item(KIND_ADDR_CHAR, "Q");
      send_item(KIND_FRAME_END, 8'hff);
      wait_for_idle();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: write_registers(8'h00, 8'h00);
            1: write_registers(8'hff, 8'hff);
            default: write_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         endcase
         target = item_count + RANDOM_ITEMS / 4;
         while (item_count < target)
            send_random_frame();
         wait_for_idle();
      end

      // receiver holds off while the sender keeps offering, so the input stalls
      hold_cycles = HOLD_OFF_CYCLES;
      hold_request = 1'b1;
      send_calm = 1'b1;
      repeat (3) send_random_address();
      repeat (30) send_item(KIND_DATA, 8'($urandom_range(0, 255)));
      send_item(KIND_FRAME_END, 8'($urandom_range(0, 255)));
      wait_for_idle();

      if (frames.pending() != 0)
         frames.report($sformatf("%0d expected bytes never arrived", frames.pending()));
      if (frames.failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/ax25fa_pkg.sv
hw/rtl/ax25fa_front.sv
hw/rtl/ax25fa_cmdq.sv
hw/rtl/ax25fa_back.sv
hw/rtl/ax25_ui_frame_assembler.sv
test/testbench.sv
